### hdl/sreel_pkg.sv
// ----------------------------------------------------------------------------
// sreel_pkg
// Shared constants for the sensor rising edge event log.
// ----------------------------------------------------------------------------
package sreel_pkg;

    localparam int HISTORY_SLOTS      = 16;
    localparam int MODULE_COUNT       = 5;
    localparam int SENSORS_PER_MODULE = 16;

    localparam int OP_W      = 1;
    localparam int MODULE_W  = 3;
    localparam int BITS_W    = 16;
    localparam int POS_W     = 4;
    localparam int SENSOR_W  = 5;
    localparam int COUNT_W   = 4;
    localparam int ENTRY_W   = MODULE_W + SENSOR_W;

    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
    localparam logic [OP_W-1:0] OP_READ   = 1'b1;

endpackage

### hdl/sreel_ram.sv
// ----------------------------------------------------------------------------
// sreel_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sreel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sensor_rising_edge_event_log_unit.sv
// Read op: an accepted beat moves the unit to the reply state, which
// registers the result beat once the output is free. Sample op: the edge
// state checks the word, then the scan walks the sensors from sensor 1 up,
// one sensor per cycle while the output is not stalled, and emits one event
// beat per rising bit. A new input beat is taken only when the unit is idle.
// Reset clears all previous words and empties the history ring at once.
// ----------------------------------------------------------------------------
// sensor_rising_edge_event_log_unit
// Rising edge detector over per-module contact words with an event history
// ring that keeps the newest HISTORY_SLOTS - 1 events.
// ----------------------------------------------------------------------------
module sensor_rising_edge_event_log_unit #(
    parameter int HISTORY_SLOTS      = sreel_pkg::HISTORY_SLOTS,
    parameter int MODULE_COUNT       = sreel_pkg::MODULE_COUNT,
    parameter int SENSORS_PER_MODULE = sreel_pkg::SENSORS_PER_MODULE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sreel_pkg::OP_W-1:0]     i_op,
    input  logic [sreel_pkg::MODULE_W-1:0] i_module_index,
    input  logic [sreel_pkg::BITS_W-1:0]   i_sensor_bits,
    input  logic [sreel_pkg::POS_W-1:0]    i_history_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sreel_pkg::MODULE_W-1:0] o_event_module,
    output logic [sreel_pkg::SENSOR_W-1:0] o_event_sensor,
    output logic                           o_entry_valid,
    output logic [sreel_pkg::COUNT_W-1:0]  o_history_count,
    output logic                           o_last_result
);

    localparam int CW   = $clog2(HISTORY_SLOTS);
    localparam int BW   = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
    localparam int S    = SENSORS_PER_MODULE;
    localparam int SNW  = $clog2(SENSORS_PER_MODULE + 1);
    localparam int CMPW = ((CW > sreel_pkg::POS_W) ? CW : sreel_pkg::POS_W) + 1;
    localparam int MCW  = sreel_pkg::MODULE_W + 2;

    localparam logic [CMPW-1:0] SLOTS_C   = CMPW'(HISTORY_SLOTS);
    localparam logic [CW-1:0]   LAST_SLOT = CW'(HISTORY_SLOTS - 1);
    localparam logic [MCW-1:0]  MOD_LIMIT = MCW'(MODULE_COUNT);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EDGE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_REPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [MODULE_COUNT-1:0] r_bank_vld, n_bank_vld;
    logic [CW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_next, n_next;
    logic [CW-1:0] r_count, n_count;
    logic r_out_vld, n_out_vld;

    logic [sreel_pkg::MODULE_W-1:0] r_module, n_module;
    logic [S-1:0] r_cur, n_cur;
    logic r_hit, n_hit;
    logic [S-1:0] r_rise, n_rise;
    logic [SNW-1:0] r_sensor, n_sensor;

    logic [sreel_pkg::MODULE_W-1:0] r_o_module, n_o_module;
    logic [sreel_pkg::SENSOR_W-1:0] r_o_sensor, n_o_sensor;
    logic r_o_valid, n_o_valid;
    logic [sreel_pkg::COUNT_W-1:0] r_o_count, n_o_count;
    logic r_o_last, n_o_last;

    logic in_acc;
    logic out_free;
    logic mod_ok;
    logic hit_now;
    logic [CMPW-1:0] pos_sum;
    logic [CMPW-1:0] pos_wrap;

    logic bank_rd_en;
    logic bank_wr_en;
    logic [BW-1:0] bank_idx;
    logic [S-1:0] bank_rd_data;
    logic [S-1:0] prev_word;
    logic [S-1:0] rising;

    logic hist_rd_en;
    logic hist_wr_en;
    logic [CW-1:0] hist_rd_addr;
    logic [sreel_pkg::ENTRY_W-1:0] hist_wr_data;
    logic [sreel_pkg::ENTRY_W-1:0] hist_rd_data;

    logic top_bit;
    logic [S-1:0] rest;
    logic emit;
    logic [CW-1:0] push_next;
    logic [CW-1:0] push_oldest;
    logic [CW-1:0] push_count;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign mod_ok   = MCW'(i_module_index) < MOD_LIMIT;
    assign hit_now  = CMPW'(i_history_position) < CMPW'(r_count);
    assign pos_sum  = CMPW'(r_oldest) + CMPW'(i_history_position);
    assign pos_wrap = (pos_sum >= SLOTS_C) ? (pos_sum - SLOTS_C) : pos_sum;

    assign bank_rd_en   = in_acc && (i_op == sreel_pkg::OP_SAMPLE) && mod_ok;
    assign bank_wr_en   = (r_state == S_EDGE);
    assign bank_idx     = (r_state == S_IDLE) ? BW'(i_module_index) : BW'(r_module);
    assign prev_word    = r_bank_vld[BW'(r_module)] ? bank_rd_data : '0;
    assign rising       = r_cur & ~prev_word;

    assign hist_rd_en   = in_acc && (i_op == sreel_pkg::OP_READ) && hit_now;
    assign hist_rd_addr = CW'(pos_wrap);
    assign hist_wr_data = {r_module, sreel_pkg::SENSOR_W'(r_sensor)};

    assign top_bit = r_rise[S-1];
    assign rest    = r_rise << 1;
    assign emit    = (r_state == S_SCAN) && top_bit && out_free;
    assign hist_wr_en = emit;

    assign push_next   = (r_next == LAST_SLOT) ? '0 : r_next + 1'b1;
    assign push_oldest = (r_count == LAST_SLOT) ?
                         ((r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1) : r_oldest;
    assign push_count  = (r_count == LAST_SLOT) ? r_count : r_count + 1'b1;

    sreel_ram #(
        .WIDTH (S),
        .DEPTH (MODULE_COUNT),
        .AW    (BW)
    ) u_bank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bank_wr_en),
        .i_wr_addr (bank_idx),
        .i_wr_data (r_cur),
        .i_rd_en   (bank_rd_en),
        .i_rd_addr (bank_idx),
        .o_rd_data (bank_rd_data)
    );

    sreel_ram #(
        .WIDTH (sreel_pkg::ENTRY_W),
        .DEPTH (HISTORY_SLOTS),
        .AW    (CW)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (r_next),
        .i_wr_data (hist_wr_data),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_bank_vld = r_bank_vld;
        n_oldest   = r_oldest;
        n_next     = r_next;
        n_count    = r_count;
        n_out_vld  = r_out_vld && i_out_stall;
        n_module   = r_module;
        n_cur      = r_cur;
        n_hit      = r_hit;
        n_rise     = r_rise;
        n_sensor   = r_sensor;
        n_o_module = r_o_module;
        n_o_sensor = r_o_sensor;
        n_o_valid  = r_o_valid;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_module = i_module_index;
                    n_cur    = S'(i_sensor_bits);
                    n_hit    = hit_now;
                    if (i_op == sreel_pkg::OP_READ) begin
                        n_state = S_REPLY;
                    end else if (mod_ok) begin
                        n_state = S_EDGE;
                    end
                end
            end
            S_EDGE: begin
                n_bank_vld[BW'(r_module)] = 1'b1;
                n_rise   = rising;
                n_sensor = SNW'(1);
                n_state  = (rising == '0) ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (!top_bit) begin
                    n_rise   = rest;
                    n_sensor = r_sensor + 1'b1;
                end else if (out_free) begin
                    n_rise     = rest;
                    n_sensor   = r_sensor + 1'b1;
                    n_next     = push_next;
                    n_oldest   = push_oldest;
                    n_count    = push_count;
                    n_out_vld  = 1'b1;
                    n_o_module = r_module;
                    n_o_sensor = sreel_pkg::SENSOR_W'(r_sensor);
                    n_o_valid  = 1'b1;
                    n_o_count  = sreel_pkg::COUNT_W'(push_count);
                    n_o_last   = (rest == '0);
                    if (rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_o_module = r_hit ? hist_rd_data[sreel_pkg::ENTRY_W-1:sreel_pkg::SENSOR_W]
                                       : '0;
                    n_o_sensor = r_hit ? hist_rd_data[sreel_pkg::SENSOR_W-1:0] : '0;
                    n_o_valid  = r_hit;
                    n_o_count  = sreel_pkg::COUNT_W'(r_count);
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bank_vld <= '0;
            r_oldest   <= '0;
            r_next     <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_bank_vld <= n_bank_vld;
            r_oldest   <= n_oldest;
            r_next     <= n_next;
            r_count    <= n_count;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_module   <= n_module;
        r_cur      <= n_cur;
        r_hit      <= n_hit;
        r_rise     <= n_rise;
        r_sensor   <= n_sensor;
        r_o_module <= n_o_module;
        r_o_sensor <= n_o_sensor;
        r_o_valid  <= n_o_valid;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_event_module  = r_o_module;
    assign o_event_sensor  = r_o_sensor;
    assign o_entry_valid   = r_o_valid;
    assign o_history_count = r_o_count;
    assign o_last_result   = r_o_last;

endmodule

### hdl/sreel_checker.sv
// ----------------------------------------------------------------------------
// sreel_checker
// Port-level checks for the sensor rising edge event log.
// ----------------------------------------------------------------------------
module sreel_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic [sreel_pkg::OP_W-1:0]     i_op,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [sreel_pkg::MODULE_W-1:0] o_event_module,
    input logic [sreel_pkg::SENSOR_W-1:0] o_event_sensor,
    input logic                           o_entry_valid,
    input logic [sreel_pkg::COUNT_W-1:0]  o_history_count,
    input logic                           o_last_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_module)
            && $stable(o_event_sensor) && $stable(o_entry_valid)
            && $stable(o_history_count) && $stable(o_last_result))
        else $error("output beat changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_event_module == '0
            && o_event_sensor == '0 && o_last_result)
        else $error("empty read beat carries data");

    a_sensor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_valid |-> o_event_sensor != '0)
        else $error("valid beat with sensor zero");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == sreel_pkg::OP_READ |=> o_in_stall)
        else $error("read beat did not hold off the input");

endmodule

bind sensor_rising_edge_event_log_unit sreel_checker u_sreel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_op            (i_op),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_event_module  (o_event_module),
    .o_event_sensor  (o_event_sensor),
    .o_entry_valid   (o_entry_valid),
    .o_history_count (o_history_count),
    .o_last_result   (o_last_result)
);

### verif/tb_sensor_rising_edge_event_log_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_rising_edge_event_log_unit
// Drives sensor word samples and history reads into the event log unit with
// random gaps on the input side and random stalls on the result side. A
// tracker mirrors the previous word of each module and the history ring and
// queues the beats each accepted item should produce. Every result beat is
// checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module tb_sensor_rising_edge_event_log_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 210;
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [sreel_pkg::MODULE_W-1:0] mod_id;
        logic [sreel_pkg::SENSOR_W-1:0] sensor;
        logic                           valid;
        logic [sreel_pkg::COUNT_W-1:0]  count;
        logic                           last;
    } t_log_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [sreel_pkg::OP_W-1:0]     i_op = sreel_pkg::OP_SAMPLE;
    logic [sreel_pkg::MODULE_W-1:0] i_module_index = '0;
    logic [sreel_pkg::BITS_W-1:0]   i_sensor_bits = '0;
    logic [sreel_pkg::POS_W-1:0]    i_history_position = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [sreel_pkg::MODULE_W-1:0] o_event_module;
    logic [sreel_pkg::SENSOR_W-1:0] o_event_sensor;
    logic                           o_entry_valid;
    logic [sreel_pkg::COUNT_W-1:0]  o_history_count;
    logic                           o_last_result;

    logic [sreel_pkg::BITS_W-1:0]   last_word [sreel_pkg::MODULE_COUNT] = '{default: '0};
    logic [sreel_pkg::MODULE_W-1:0] ring_mod [sreel_pkg::HISTORY_SLOTS];
    logic [sreel_pkg::SENSOR_W-1:0] ring_sensor [sreel_pkg::HISTORY_SLOTS];
    int                             ring_head = 0;
    int                             ring_tail = 0;
    t_log_beat                      due_beats [$];
    int                             fail_count = 0;
    bit                             send_burst = 1'b0;
    bit                             take_burst = 1'b0;

    sensor_rising_edge_event_log_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_module_index     (i_module_index),
        .i_sensor_bits      (i_sensor_bits),
        .i_history_position (i_history_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_event_module     (o_event_module),
        .o_event_sensor     (o_event_sensor),
        .o_entry_valid      (o_entry_valid),
        .o_history_count    (o_history_count),
        .o_last_result      (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic int ring_fill();
        return (ring_tail + sreel_pkg::HISTORY_SLOTS - ring_head) % sreel_pkg::HISTORY_SLOTS;
    endfunction

    function automatic void predict_beats(input logic [sreel_pkg::OP_W-1:0] op,
                                          input logic [sreel_pkg::MODULE_W-1:0] mod,
                                          input logic [sreel_pkg::BITS_W-1:0] bits,
                                          input logic [sreel_pkg::POS_W-1:0] pos);
        t_log_beat                    beat;
        logic [sreel_pkg::BITS_W-1:0] rise;
        int                           slot;
        int                           bitpos;
        beat = '0;
        if (op == sreel_pkg::OP_READ) begin
            beat.count = sreel_pkg::COUNT_W'(ring_fill());
            beat.last = 1'b1;
            if (int'(pos) < ring_fill()) begin
                slot = (ring_head + int'(pos)) % sreel_pkg::HISTORY_SLOTS;
                beat.mod_id = ring_mod[slot];
                beat.sensor = ring_sensor[slot];
                beat.valid = 1'b1;
            end
            due_beats.push_back(beat);
        end else if (int'(mod) < sreel_pkg::MODULE_COUNT) begin
            rise = bits & ~last_word[mod];
            last_word[mod] = bits;
            for (int s = 1; s <= sreel_pkg::SENSORS_PER_MODULE; s++) begin
                bitpos = sreel_pkg::SENSORS_PER_MODULE - s;
                if (rise[bitpos]) begin
                    ring_mod[ring_tail] = mod;
                    ring_sensor[ring_tail] = sreel_pkg::SENSOR_W'(s);
                    ring_tail = (ring_tail + 1) % sreel_pkg::HISTORY_SLOTS;
                    if (ring_tail == ring_head) begin
                        ring_head = (ring_head + 1) % sreel_pkg::HISTORY_SLOTS;
                    end
                    beat.mod_id = mod;
                    beat.sensor = sreel_pkg::SENSOR_W'(s);
                    beat.valid = 1'b1;
                    beat.count = sreel_pkg::COUNT_W'(ring_fill());
                    beat.last = ((32'(rise) & ((32'd1 << bitpos) - 1)) == 0);
                    due_beats.push_back(beat);
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    task automatic send_item(input logic [sreel_pkg::OP_W-1:0] op,
                             input logic [sreel_pkg::MODULE_W-1:0] mod,
                             input logic [sreel_pkg::BITS_W-1:0] bits,
                             input logic [sreel_pkg::POS_W-1:0] pos);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_module_index <= mod;
        i_sensor_bits <= bits;
        i_history_position <= pos;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        predict_beats(op, mod, bits, pos);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic take_result();
        t_log_beat want;
        if (due_beats.size() == 0) begin
            report_mismatch("unexpected beat", 32'({o_event_module, o_event_sensor}), 32'd0);
            return;
        end
        want = due_beats.pop_front();
        if (o_event_module !== want.mod_id) begin
            report_mismatch("event_module", 32'(o_event_module), 32'(want.mod_id));
        end
        if (o_event_sensor !== want.sensor) begin
            report_mismatch("event_sensor", 32'(o_event_sensor), 32'(want.sensor));
        end
        if (o_entry_valid !== want.valid) begin
            report_mismatch("entry_valid", 32'(o_entry_valid), 32'(want.valid));
        end
        if (o_history_count !== want.count) begin
            report_mismatch("history_count", 32'(o_history_count), 32'(want.count));
        end
        if (o_last_result !== want.last) begin
            report_mismatch("last_result", 32'(o_last_result), 32'(want.last));
        end
    endtask

    task automatic test_empty_reads();
        send_item(sreel_pkg::OP_READ, '0, '0, '0);
        send_item(sreel_pkg::OP_READ, sreel_pkg::MODULE_W'(7), '1, sreel_pkg::POS_W'(15));
    endtask

    task automatic test_single_edges();
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(0), 16'h8000, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(4), 16'h0001, '0);
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(0));
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(1));
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(2));
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(0), 16'h8000, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(0), 16'h0000, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(0), 16'h8000, '0);
    endtask

    task automatic test_full_words();
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(2), '1, sreel_pkg::POS_W'(15));
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(2), '1, '0);
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(0));
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(14));
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(15));
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(3), 16'h5555, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(3), 16'hFFFF, '0);
    endtask

    task automatic test_bad_modules();
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(5), '1, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(6), '1, '0);
        send_item(sreel_pkg::OP_SAMPLE, sreel_pkg::MODULE_W'(7), '1, '0);
        send_item(sreel_pkg::OP_READ, '0, '0, sreel_pkg::POS_W'(14));
    endtask

    task automatic test_random_traffic();
        int                             counted;
        int                             roll;
        bit                             paused;
        logic [sreel_pkg::MODULE_W-1:0] mod;
        logic [sreel_pkg::BITS_W-1:0]   word;
        counted = 0;
        paused = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 30 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
                take_burst = ($urandom_range(0, 3) == 0);
            end
            if (!paused && counted >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_item(sreel_pkg::OP_READ, sreel_pkg::MODULE_W'($urandom),
                          sreel_pkg::BITS_W'($urandom), sreel_pkg::POS_W'($urandom));
                counted++;
            end else if (roll < 40) begin
                mod = sreel_pkg::MODULE_W'($urandom_range(sreel_pkg::MODULE_COUNT, 7));
                send_item(sreel_pkg::OP_SAMPLE, mod, sreel_pkg::BITS_W'($urandom),
                          sreel_pkg::POS_W'($urandom));
            end else begin
                mod = sreel_pkg::MODULE_W'($urandom_range(0, sreel_pkg::MODULE_COUNT - 1));
                case ($urandom_range(0, 3))
                    0: word = sreel_pkg::BITS_W'($urandom);
                    1: word = last_word[mod]
                              | (sreel_pkg::BITS_W'(1) << $urandom_range(0, 15));
                    2: word = '0;
                    default: word = '1;
                endcase
                send_item(sreel_pkg::OP_SAMPLE, mod, word, sreel_pkg::POS_W'($urandom));
                counted++;
            end
        end
        send_burst = 1'b0;
        take_burst = 1'b0;
    endtask

    initial begin : result_checker
        int hold;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = take_burst ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            take_result();
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_reads();
        test_single_edges();
        test_full_words();
        test_bad_modules();
        drain_results();
        test_random_traffic();
        drain_results();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
